// ===== src/bpfa_pkg.sv =====
// bpfa_pkg: shared constants, types and state codes of the page frame allocator
// used by bpfa_alu and bitmap_page_frame_allocator_core

package bpfa_pkg;

    localparam int MAP_WORDS   = 1024;
    localparam int PAGE_BYTES  = 4096;
    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
    localparam int WORD_BITS   = 64;
    localparam int BIT_W       = 6;
    localparam int WIDX_W      = $clog2(MAP_WORDS);
    localparam int PIDX_W      = WIDX_W + BIT_W;
    localparam int CNT_W       = PIDX_W + 1;
    localparam int ROW_W       = WIDX_W - BIT_W;
    localparam int SUM_ROWS    = MAP_WORDS / WORD_BITS;
    localparam int TOTAL_PAGES = MAP_WORDS * WORD_BITS;
    localparam int PAGE_W      = 64 - PAGE_SHIFT;
    localparam int NUM_W       = PAGE_W + 1;

    typedef logic [63:0] t_word;

    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_FREE    = 2'd1;
    localparam logic [1:0] ACT_RESERVE = 2'd2;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_OOM  = 2'd1,
        ST_IGN  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIFF,
        S_CHECK,
        S_RANGE,
        S_FIND,
        S_PICK,
        S_READ,
        S_MOD,
        S_USED,
        S_ADDR,
        S_DONE
    } t_state;

    typedef struct packed {
        t_word a;
        t_word b;
        logic  sub;
    } t_alu_req;

endpackage

// ===== src/bpfa_ram.sv =====
// bpfa_ram: generic single write port, single read port ram with registered read
// no package dependency

module bpfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== src/bpfa_alu.sv =====
// bpfa_alu: shared 64-bit add/subtract unit of the allocator sequencer
// depends on bpfa_pkg for the request struct

module bpfa_alu (
    input  bpfa_pkg::t_alu_req i_req,
    output bpfa_pkg::t_word    o_sum,
    output logic               o_borrow
);

    logic [64:0] w_full;

    assign w_full   = {1'b0, i_req.a} + {1'b0, (i_req.sub ? ~i_req.b : i_req.b)}
                    + 65'(i_req.sub);
    assign o_sum    = w_full[63:0];
    assign o_borrow = i_req.sub & ~w_full[64];

endmodule

// ===== src/bpfa_lsb.sv =====
// bpfa_lsb: lowest set bit finder over one 64-bit word, binary search in six levels
// no package dependency

module bpfa_lsb (
    input  logic [63:0] i_vec,
    output logic [5:0]  o_idx
);

    logic [63:0] v;

    always_comb begin
        v     = i_vec;
        o_idx = '0;
        for (int k = 5; k >= 0; k--) begin
            if ((v & ((64'd1 << (1 << k)) - 64'd1)) == 64'd0) begin
                o_idx[k] = 1'b1;
                v        = v >> (1 << k);
            end
        end
    end

endmodule

// ===== src/bitmap_page_frame_allocator_core.sv =====
// bitmap_page_frame_allocator_core: first-free page allocator over a bitmap in ram
// one request at a time; the map ram port and one shared 64-bit adder set the pace
// reset: synchronous; then a clear pass fills every map word with ones
// depends on bpfa_pkg, bpfa_ram, bpfa_alu, bpfa_lsb

module bitmap_page_frame_allocator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic [63:0] i_address,
    input  logic [63:0] i_byte_count,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_page_address,
    output logic [1:0]  o_status,
    output logic [63:0] o_used_total
);

    bpfa_pkg::t_state  r_state, n_state;
    bpfa_pkg::t_status r_status;

    logic [63:0] r_base, r_used, r_addr, r_bc, r_diff, r_page_addr;
    logic [1:0]  r_action;
    logic        r_below;
    logic [bpfa_pkg::WIDX_W-1:0] r_clr, r_word, r_first_word, r_last_word;
    logic [bpfa_pkg::BIT_W-1:0]  r_first_bit, r_last_bit, r_bit;
    logic [bpfa_pkg::PIDX_W-1:0] r_start;
    logic [bpfa_pkg::NUM_W-1:0]  r_num;
    logic [bpfa_pkg::ROW_W-1:0]  r_row;
    logic [63:0] r_sum [bpfa_pkg::SUM_ROWS];

    logic        r_out_valid;
    logic [63:0] r_out_page, r_out_used;
    logic [1:0]  r_out_status;

    bpfa_pkg::t_alu_req w_alu_req;
    logic [63:0] w_alu_sum;
    logic        w_alu_borrow;

    logic        w_ram_we;
    logic [bpfa_pkg::WIDX_W-1:0] w_ram_waddr;
    logic [63:0] w_ram_wdata, w_rdata;

    logic [bpfa_pkg::SUM_ROWS-1:0] w_row_nz;
    logic [5:0]  w_row_idx, w_sum_idx, w_word_idx;
    logic        w_row_any;

    logic [bpfa_pkg::PAGE_W-1:0] w_page;
    logic        w_page_in;
    logic [bpfa_pkg::NUM_W-1:0]  w_num;
    logic [bpfa_pkg::CNT_W-1:0]  w_room, w_n, w_last;
    logic        w_take_num;
    logic [5:0]  w_lo, w_hi;
    logic [63:0] w_mask, w_new;
    logic        w_accept, w_out_take, w_done_go, w_more;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_take = r_out_valid && !i_out_stall;
    assign w_done_go  = !r_out_valid || !i_out_stall;

    assign o_in_stall     = (r_state != bpfa_pkg::S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_page_address = r_out_page;
    assign o_status       = r_out_status;
    assign o_used_total   = r_out_used;

    bpfa_ram #(
        .WIDTH(64),
        .DEPTH(bpfa_pkg::MAP_WORDS)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(w_ram_waddr),
        .i_wdata(w_ram_wdata),
        .i_raddr(r_word),
        .o_rdata(w_rdata)
    );

    bpfa_alu u_alu (
        .i_req   (w_alu_req),
        .o_sum   (w_alu_sum),
        .o_borrow(w_alu_borrow)
    );

    always_comb begin
        for (int r = 0; r < bpfa_pkg::SUM_ROWS; r++) begin
            w_row_nz[r] = |r_sum[r];
        end
    end
    assign w_row_any = |w_row_nz;

    bpfa_lsb u_lsb_row (
        .i_vec(64'(w_row_nz)),
        .o_idx(w_row_idx)
    );

    bpfa_lsb u_lsb_sum (
        .i_vec(r_sum[r_row]),
        .o_idx(w_sum_idx)
    );

    bpfa_lsb u_lsb_word (
        .i_vec(w_rdata),
        .o_idx(w_word_idx)
    );

    // address checks and reserve range
    assign w_page     = r_diff[63:bpfa_pkg::PAGE_SHIFT];
    assign w_page_in  = w_page < bpfa_pkg::PAGE_W'(bpfa_pkg::TOTAL_PAGES);
    assign w_num      = bpfa_pkg::NUM_W'(r_bc[63:bpfa_pkg::PAGE_SHIFT])
                      + bpfa_pkg::NUM_W'(|r_bc[bpfa_pkg::PAGE_SHIFT-1:0]);
    assign w_room     = bpfa_pkg::CNT_W'(bpfa_pkg::TOTAL_PAGES) - {1'b0, r_start};
    assign w_take_num = r_num < bpfa_pkg::NUM_W'(w_room);
    assign w_n        = w_take_num ? r_num[bpfa_pkg::CNT_W-1:0] : w_room;
    assign w_last     = {1'b0, r_start} + w_n - bpfa_pkg::CNT_W'(1);

    // word update
    assign w_lo   = (r_word == r_first_word) ? r_first_bit : 6'd0;
    assign w_hi   = (r_word == r_last_word) ? r_last_bit : 6'd63;
    assign w_more = (r_action == bpfa_pkg::ACT_RESERVE) && (r_word != r_last_word);

    always_comb begin
        case (r_action)
            bpfa_pkg::ACT_ALLOC: begin
                w_mask = w_rdata & (~w_rdata + 64'd1);
                w_new  = w_rdata & ~w_mask;
            end
            bpfa_pkg::ACT_FREE: begin
                w_mask = ({64{1'b1}} << w_lo) & ({64{1'b1}} >> (6'd63 - w_hi));
                w_new  = w_rdata | w_mask;
            end
            default: begin
                w_mask = ({64{1'b1}} << w_lo) & ({64{1'b1}} >> (6'd63 - w_hi));
                w_new  = w_rdata & ~w_mask;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bpfa_pkg::S_CLEAR: begin
                if (r_clr == bpfa_pkg::WIDX_W'(bpfa_pkg::MAP_WORDS - 1)) begin
                    n_state = bpfa_pkg::S_IDLE;
                end
            end
            bpfa_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = bpfa_pkg::S_DIFF;
                end
            end
            bpfa_pkg::S_DIFF: begin
                case (r_action)
                    bpfa_pkg::ACT_ALLOC:   n_state = bpfa_pkg::S_FIND;
                    bpfa_pkg::ACT_FREE:    n_state = bpfa_pkg::S_CHECK;
                    bpfa_pkg::ACT_RESERVE: n_state = bpfa_pkg::S_CHECK;
                    default:               n_state = bpfa_pkg::S_DONE;
                endcase
            end
            bpfa_pkg::S_CHECK: begin
                if (r_action == bpfa_pkg::ACT_FREE) begin
                    n_state = (!r_below && w_page_in) ? bpfa_pkg::S_READ : bpfa_pkg::S_DONE;
                end else if (r_base == 64'd0 || r_below) begin
                    n_state = bpfa_pkg::S_DONE;
                end else if (!w_page_in || w_num == '0) begin
                    n_state = bpfa_pkg::S_USED;
                end else begin
                    n_state = bpfa_pkg::S_RANGE;
                end
            end
            bpfa_pkg::S_RANGE: n_state = bpfa_pkg::S_READ;
            bpfa_pkg::S_FIND: begin
                n_state = w_row_any ? bpfa_pkg::S_PICK : bpfa_pkg::S_DONE;
            end
            bpfa_pkg::S_PICK: n_state = bpfa_pkg::S_READ;
            bpfa_pkg::S_READ: n_state = bpfa_pkg::S_MOD;
            bpfa_pkg::S_MOD: begin
                n_state = w_more ? bpfa_pkg::S_READ : bpfa_pkg::S_USED;
            end
            bpfa_pkg::S_USED: begin
                n_state = (r_action == bpfa_pkg::ACT_ALLOC) ? bpfa_pkg::S_ADDR
                                                            : bpfa_pkg::S_DONE;
            end
            bpfa_pkg::S_ADDR: n_state = bpfa_pkg::S_DONE;
            bpfa_pkg::S_DONE: begin
                if (w_done_go) begin
                    n_state = bpfa_pkg::S_IDLE;
                end
            end
            default: n_state = bpfa_pkg::S_IDLE;
        endcase
    end

    // per-state controls: map write port and shared adder operands
    always_comb begin
        w_ram_we      = 1'b0;
        w_ram_waddr   = r_word;
        w_ram_wdata   = w_new;
        w_alu_req.a   = r_addr;
        w_alu_req.b   = r_base;
        w_alu_req.sub = 1'b1;
        case (r_state)
            bpfa_pkg::S_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_clr;
                w_ram_wdata = {64{1'b1}};
            end
            bpfa_pkg::S_MOD: begin
                w_ram_we = 1'b1;
            end
            bpfa_pkg::S_USED: begin
                w_alu_req.a = r_used;
                case (r_action)
                    bpfa_pkg::ACT_FREE: begin
                        w_alu_req.b   = 64'(bpfa_pkg::PAGE_BYTES);
                        w_alu_req.sub = 1'b1;
                    end
                    bpfa_pkg::ACT_RESERVE: begin
                        w_alu_req.b   = r_bc;
                        w_alu_req.sub = 1'b0;
                    end
                    default: begin
                        w_alu_req.b   = 64'(bpfa_pkg::PAGE_BYTES);
                        w_alu_req.sub = 1'b0;
                    end
                endcase
            end
            bpfa_pkg::S_ADDR: begin
                w_alu_req.a   = r_base;
                w_alu_req.b   = 64'({r_word, r_bit}) << bpfa_pkg::PAGE_SHIFT;
                w_alu_req.sub = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bpfa_pkg::S_CLEAR;
            r_clr       <= '0;
            r_base      <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata;
            end
            if (r_state == bpfa_pkg::S_CLEAR) begin
                r_clr <= r_clr + bpfa_pkg::WIDX_W'(1);
            end
            if (r_state == bpfa_pkg::S_USED) begin
                r_used <= w_alu_sum;
            end
            if (r_state == bpfa_pkg::S_DONE && w_done_go) begin
                r_out_valid <= 1'b1;
            end else if (w_out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // summary bit per map word, set while the word has a free page
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < bpfa_pkg::SUM_ROWS; r++) begin
                r_sum[r] <= {64{1'b1}};
            end
        end else if (r_state == bpfa_pkg::S_MOD) begin
            r_sum[r_word[bpfa_pkg::WIDX_W-1:bpfa_pkg::BIT_W]][r_word[bpfa_pkg::BIT_W-1:0]]
                <= |w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            bpfa_pkg::S_IDLE: begin
                if (w_accept) begin
                    r_action    <= i_action;
                    r_addr      <= i_address;
                    r_bc        <= i_byte_count;
                    r_status    <= bpfa_pkg::ST_IGN;
                    r_page_addr <= '0;
                end
            end
            bpfa_pkg::S_DIFF: begin
                r_diff  <= w_alu_sum;
                r_below <= w_alu_borrow;
            end
            bpfa_pkg::S_CHECK: begin
                r_start      <= w_page[bpfa_pkg::PIDX_W-1:0];
                r_num        <= w_num;
                r_word       <= w_page[bpfa_pkg::PIDX_W-1:bpfa_pkg::BIT_W];
                r_first_word <= w_page[bpfa_pkg::PIDX_W-1:bpfa_pkg::BIT_W];
                r_last_word  <= w_page[bpfa_pkg::PIDX_W-1:bpfa_pkg::BIT_W];
                r_first_bit  <= w_page[bpfa_pkg::BIT_W-1:0];
                r_last_bit   <= w_page[bpfa_pkg::BIT_W-1:0];
                if (r_action == bpfa_pkg::ACT_FREE) begin
                    if (!r_below && w_page_in) begin
                        r_status <= bpfa_pkg::ST_DONE;
                    end
                end else if (r_base != 64'd0 && !r_below) begin
                    r_status <= bpfa_pkg::ST_DONE;
                end
            end
            bpfa_pkg::S_RANGE: begin
                r_word       <= r_start[bpfa_pkg::PIDX_W-1:bpfa_pkg::BIT_W];
                r_first_word <= r_start[bpfa_pkg::PIDX_W-1:bpfa_pkg::BIT_W];
                r_first_bit  <= r_start[bpfa_pkg::BIT_W-1:0];
                r_last_word  <= w_last[bpfa_pkg::PIDX_W-1:bpfa_pkg::BIT_W];
                r_last_bit   <= w_last[bpfa_pkg::BIT_W-1:0];
            end
            bpfa_pkg::S_FIND: begin
                r_row    <= w_row_idx[bpfa_pkg::ROW_W-1:0];
                r_status <= w_row_any ? bpfa_pkg::ST_DONE : bpfa_pkg::ST_OOM;
            end
            bpfa_pkg::S_PICK: begin
                r_word       <= {r_row, w_sum_idx};
                r_first_word <= {r_row, w_sum_idx};
                r_last_word  <= {r_row, w_sum_idx};
            end
            bpfa_pkg::S_MOD: begin
                r_bit <= w_word_idx;
                if (w_more) begin
                    r_word <= r_word + bpfa_pkg::WIDX_W'(1);
                end
            end
            bpfa_pkg::S_ADDR: begin
                r_page_addr <= w_alu_sum;
            end
            bpfa_pkg::S_DONE: begin
                if (w_done_go) begin
                    r_out_page   <= r_page_addr;
                    r_out_status <= r_status;
                    r_out_used   <= r_used;
                end
            end
            default: begin
            end
        endcase
    end

endmodule
